@@ rtl/brsc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bit range scan, enumerate and count unit.
// No dependencies; imported by every module of the block.
package brsc_pkg;

    localparam int WORD_BITS      = 64;
    localparam int POS_BITS       = 32;
    localparam int INDEX_BITS     = 26;
    localparam int RANGE_BITS     = 33;
    localparam int COUNT_BITS     = 33;
    localparam int IDX_BITS       = $clog2(WORD_BITS);
    localparam int OFS_BITS       = IDX_BITS + 1;
    localparam int POP_BITS       = $clog2(WORD_BITS + 1);
    localparam int LANE_BITS      = 8;
    localparam int LANES          = WORD_BITS / LANE_BITS;
    localparam int LANE_POP_BITS  = $clog2(LANE_BITS + 1);
    localparam int MODE_BITS      = 2;
    localparam int REG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = RANGE_BITS;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam int IN_FIELD_BITS  = INDEX_BITS + 2 * WORD_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = POS_BITS + COUNT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;
    localparam int OUT_TUSER_BITS = 2;

    // tuser bit positions on the result channel
    localparam int TUSER_POS_VALID = 0;
    localparam int TUSER_SCAN_DONE = 1;

    // match mode codes; the unused code behaves as MODE_AND
    localparam logic [MODE_BITS-1:0] MODE_ONES  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ZEROS = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_AND   = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_MATCH_MODE  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_RANGE_BEGIN = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_RANGE_END   = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_EMIT_POS    = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [MODE_BITS-1:0]  match_mode;
        logic [RANGE_BITS-1:0] range_begin;
        logic [RANGE_BITS-1:0] range_end;
        logic                  emit_positions;
    } t_cfg;

    typedef struct packed {
        logic [WORD_BITS-1:0]  mask;
        logic [INDEX_BITS-1:0] index;
        logic [POP_BITS-1:0]   pop;
        logic                  last;
    } t_item;

endpackage

@@ rtl/brsc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts words, builds the qualified match mask and counts it.
// Depends on brsc_pkg.
module brsc_front import brsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [INDEX_BITS-1:0] i_index,
    input  logic [WORD_BITS-1:0]  i_data,
    input  logic [WORD_BITS-1:0]  i_second,
    input  logic                  i_last,
    input  logic                  i_full,
    output logic                  o_push,
    output t_item                 o_item
);

    logic                     r_s1_v;
    logic [WORD_BITS-1:0]     r_s1_mask;
    logic [INDEX_BITS-1:0]    r_s1_index;
    logic                     r_s1_last;

    logic                     r_s2_v;
    logic [WORD_BITS-1:0]     r_s2_mask;
    logic [INDEX_BITS-1:0]    r_s2_index;
    logic                     r_s2_last;
    logic [LANE_POP_BITS-1:0] r_s2_lane [LANES];

    logic                     en;
    logic [WORD_BITS-1:0]     sel;
    logic [WORD_BITS-1:0]     range_mask;
    logic [RANGE_BITS:0]      base;
    logic [RANGE_BITS:0]      d_lo;
    logic [RANGE_BITS:0]      d_hi;
    logic [OFS_BITS-1:0]      lo;
    logic [OFS_BITS-1:0]      hi;
    logic [LANE_POP_BITS-1:0] n_lane [LANES];
    logic [POP_BITS-1:0]      pop_sum;

    // stall the whole front when the last stage cannot hand over
    assign en      = !(r_s2_v && i_full);
    assign o_ready = en;
    assign o_push  = r_s2_v && !i_full;

    always_comb begin
        unique case (i_cfg.match_mode)
            MODE_ONES:  sel = i_data;
            MODE_ZEROS: sel = ~i_data;
            default:    sel = i_data & i_second;
        endcase
    end

    // clamp the range bounds to offsets within this word
    always_comb begin
        base = (RANGE_BITS + 1)'({i_index, {IDX_BITS{1'b0}}});
        d_lo = {1'b0, i_cfg.range_begin} - base;
        d_hi = {1'b0, i_cfg.range_end} - base;
        if (d_lo[RANGE_BITS]) begin
            lo = '0;
        end else if (d_lo >= (RANGE_BITS + 1)'(WORD_BITS)) begin
            lo = OFS_BITS'(WORD_BITS);
        end else begin
            lo = d_lo[OFS_BITS-1:0];
        end
        if (d_hi[RANGE_BITS]) begin
            hi = '0;
        end else if (d_hi >= (RANGE_BITS + 1)'(WORD_BITS)) begin
            hi = OFS_BITS'(WORD_BITS);
        end else begin
            hi = d_hi[OFS_BITS-1:0];
        end
        for (int i = 0; i < WORD_BITS; i++) begin
            range_mask[i] = (OFS_BITS'(i) >= lo) && (OFS_BITS'(i) < hi);
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_lane[l] = '0;
            for (int b = 0; b < LANE_BITS; b++) begin
                n_lane[l] = n_lane[l] + LANE_POP_BITS'(r_s1_mask[l*LANE_BITS + b]);
            end
        end
        pop_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            pop_sum = pop_sum + POP_BITS'(r_s2_lane[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_mask  <= sel & range_mask;
            r_s1_index <= i_index;
            r_s1_last  <= i_last;
            r_s2_mask  <= r_s1_mask;
            r_s2_index <= r_s1_index;
            r_s2_last  <= r_s1_last;
            r_s2_lane  <= n_lane;
        end
    end

    assign o_item.mask  = r_s2_mask;
    assign o_item.index = r_s2_index;
    assign o_item.pop   = pop_sum;
    assign o_item.last  = r_s2_last;

endmodule

@@ rtl/brsc_queue.sv @@
`timescale 1ns / 1ps
// Short queue of classified words between the front and the back.
// Depends on brsc_pkg.
module brsc_queue import brsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ rtl/brsc_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the current word's matches, keeps the running count and
// holds the result register. Depends on brsc_pkg.
module brsc_back import brsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [POS_BITS-1:0]   o_position,
    output logic                  o_position_valid,
    output logic [COUNT_BITS-1:0] o_running_count,
    output logic                  o_last_of_item,
    output logic                  o_scan_done
);

    logic                  r_cur_v;
    t_item                 r_cur;
    logic [COUNT_BITS-1:0] r_total;

    logic                  r_o_valid;
    logic [POS_BITS-1:0]   r_o_pos;
    logic                  r_o_pv;
    logic [COUNT_BITS-1:0] r_o_cnt;
    logic                  r_o_last;
    logic                  r_o_done;

    logic                  slot_free;
    logic                  fire;
    logic                  walk;
    logic                  final_res;
    logic                  consume;
    logic [WORD_BITS-1:0]  lsb;
    logic [WORD_BITS-1:0]  rem_next;
    logic [IDX_BITS-1:0]   bit_idx;
    logic [POP_BITS-1:0]   inc;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] cnt;

    assign slot_free = !r_o_valid || i_ready;
    assign fire      = r_cur_v && slot_free;
    assign walk      = i_cfg.emit_positions && (r_cur.mask != '0);

    // isolate the lowest match and encode its offset
    always_comb begin
        lsb      = r_cur.mask & (~r_cur.mask + 1'b1);
        rem_next = r_cur.mask & (r_cur.mask - 1'b1);
        bit_idx  = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lsb[i]) begin
                bit_idx = bit_idx | IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        inc       = walk ? POP_BITS'(1) : r_cur.pop;
        sum       = {1'b0, r_total} + (COUNT_BITS + 1)'(inc);
        cnt       = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
        final_res = walk ? (rem_next == '0) : 1'b1;
        consume   = !r_cur_v || (fire && final_res);
    end

    assign o_q_pop = consume && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v   <= 1'b0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (consume) begin
                r_cur_v <= i_q_valid;
            end
            if (fire) begin
                r_total <= (final_res && r_cur.last) ? '0 : cnt;
            end
            if (slot_free) begin
                r_o_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_cur <= i_q_item;
        end else if (fire) begin
            r_cur.mask <= rem_next;
        end
        if (fire) begin
            r_o_pos  <= walk ? POS_BITS'({r_cur.index, bit_idx}) : '0;
            r_o_pv   <= walk;
            r_o_cnt  <= cnt;
            r_o_last <= final_res;
            r_o_done <= final_res && r_cur.last;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_position       = r_o_pos;
    assign o_position_valid = r_o_pv;
    assign o_running_count  = r_o_cnt;
    assign o_last_of_item   = r_o_last;
    assign o_scan_done      = r_o_done;

endmodule

@@ rtl/bit_range_scan_enumerate_count_unit.sv @@
`timescale 1ns / 1ps
// Top level of the bit range scan, enumerate and count unit.
// Depends on brsc_pkg, brsc_front, brsc_queue and brsc_back.
//
// Usage:
//   Words of a bit vector enter on the s_axis request channel, one 64-bit
//   word (plus the second vector's word) per request, tagged with its word
//   index; tlast marks the final word of a scan. Matching bits (ones, zeros,
//   or ones of both vectors) inside [range_begin, range_end) are counted.
//   Each word yields one or more result requests on m_axis: with position
//   output on, one request per match, lowest position first; otherwise, or
//   with no match, a single count-only request. tlast marks the final
//   result of a word, tuser carries the position-valid and scan-done flags.
//   Configuration is written over the cfg channel while the unit is idle.
// Timing:
//   A word's first result passes front stages s1 and s2, the queue, r_cur
//   and the result register. Words are taken one per cycle unless the queue
//   is full; the back end emits one result per cycle while the receiver is
//   ready (one per match with positions); a four-entry queue absorbs bursts.
// Reset and stall:
//   Reset restores the register defaults, clears the running count and
//   empties the pipeline. A stalled receiver holds the result register; the
//   queue fills, and then s_axis tready drops until space returns.
module bit_range_scan_enumerate_count_unit import brsc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // cfg write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [REG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // word input
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata from bit 0: word_index[25:0], data_word[63:0], second_word[63:0], zero pad
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    input  logic                      i_s_axis_tlast,
    // result output
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // tdata from bit 0: position[31:0], running_count[32:0], zero pad
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    output logic                      o_m_axis_tlast,
    // tuser from bit 0: position_valid, scan_done
    output logic [OUT_TUSER_BITS-1:0] o_m_axis_tuser
);

    t_cfg                  r_cfg;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    t_item                 push_item;
    t_item                 head_item;
    logic [POS_BITS-1:0]   res_pos;
    logic                  res_pv;
    logic [COUNT_BITS-1:0] res_cnt;
    logic                  res_last;
    logic                  res_done;

    // configuration registers: always ready, narrowed to each field's width
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_mode     <= MODE_ONES;
            r_cfg.range_begin    <= '0;
            r_cfg.range_end      <= '0;
            r_cfg.emit_positions <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MATCH_MODE:  r_cfg.match_mode     <= i_cfg_data[MODE_BITS-1:0];
                REG_RANGE_BEGIN: r_cfg.range_begin    <= i_cfg_data[RANGE_BITS-1:0];
                REG_RANGE_END:   r_cfg.range_end      <= i_cfg_data[RANGE_BITS-1:0];
                REG_EMIT_POS:    r_cfg.emit_positions <= i_cfg_data[0];
                default:         r_cfg                <= r_cfg;
            endcase
        end
    end

    // front: select, range-qualify and count each word
    brsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_index  (i_s_axis_tdata[INDEX_BITS-1:0]),
        .i_data   (i_s_axis_tdata[INDEX_BITS +: WORD_BITS]),
        .i_second (i_s_axis_tdata[INDEX_BITS + WORD_BITS +: WORD_BITS]),
        .i_last   (i_s_axis_tlast),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_item   (push_item)
    );

    // queue: decouple word intake from result emission
    brsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    // back: enumerate matches and advance the running count
    brsc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (q_valid),
        .i_q_item         (head_item),
        .o_q_pop          (q_pop),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_position       (res_pos),
        .o_position_valid (res_pv),
        .o_running_count  (res_cnt),
        .o_last_of_item   (res_last),
        .o_scan_done      (res_done)
    );

    assign o_m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, res_cnt, res_pos};
    assign o_m_axis_tlast = res_last;
    assign o_m_axis_tuser = {res_done, res_pv};

endmodule

@@ rtl/brsc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the bit range scan, enumerate and count unit,
// bound to the top level. Depends on brsc_pkg.
module brsc_checker import brsc_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    input logic                      o_m_axis_tlast,
    input logic [OUT_TUSER_BITS-1:0] o_m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // scan done only on the final result of a word
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[TUSER_SCAN_DONE] |-> o_m_axis_tlast)
        else $error("scan done without end of word");

    // a count-only result closes its word and carries position zero
    a_count_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[TUSER_POS_VALID] |->
            o_m_axis_tlast && (o_m_axis_tdata[POS_BITS-1:0] == '0))
        else $error("malformed count-only result");

    // a reported match has been counted
    a_match_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[TUSER_POS_VALID] |->
            (o_m_axis_tdata[POS_BITS +: COUNT_BITS] != '0))
        else $error("match reported with zero count");

endmodule

bind bit_range_scan_enumerate_count_unit brsc_checker u_brsc_checker (.*);

@@ tb/bit_range_scan_enumerate_count_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bit_range_scan_enumerate_count_unit.
// Depends on brsc_pkg and the unit's RTL; a result tracker class predicts every
// result request, and plain tasks drive the word and cfg channels.
import brsc_pkg::*;

typedef struct {
    logic [POS_BITS-1:0]   position;
    logic                  pos_valid;
    logic [COUNT_BITS-1:0] count;
    logic                  item_last;
    logic                  done;
} t_scan_result;

// Tracks register contents and the running match count, and holds the
// results still owed by the unit, oldest first.
class match_tracker;
    t_cfg                  regs;
    logic [COUNT_BITS-1:0] match_total;
    t_scan_result          owed_results[$];
    int                    errors;
    int                    results_seen;
    int                    positions_seen;
    int                    scans_done;

    function new();
        regs.match_mode     = MODE_ONES;
        regs.range_begin    = '0;
        regs.range_end      = '0;
        regs.emit_positions = 1'b1;
        match_total         = '0;
        errors              = 0;
        results_seen        = 0;
        positions_seen      = 0;
        scans_done          = 0;
    endfunction

    function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_MATCH_MODE:  regs.match_mode     = value[MODE_BITS-1:0];
            REG_RANGE_BEGIN: regs.range_begin    = value[RANGE_BITS-1:0];
            REG_RANGE_END:   regs.range_end      = value[RANGE_BITS-1:0];
            REG_EMIT_POS:    regs.emit_positions = value[0];
            default: ;
        endcase
    endfunction

    // Work out every result one accepted word causes.
    function void note_word(logic [INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] first,
                            logic [WORD_BITS-1:0] second, logic last_word);
        logic [WORD_BITS-1:0]  sel;
        logic [RANGE_BITS-1:0] pos;
        t_scan_result          r;
        bit                    have;
        case (regs.match_mode)
            MODE_ONES:  sel = first;
            MODE_ZEROS: sel = ~first;
            default:    sel = first & second;   // the spare code acts as AND
        endcase
        have = 0;
        for (int i = 0; i < WORD_BITS; i++) begin
            pos = {1'b0, idx, {IDX_BITS{1'b0}}} + RANGE_BITS'(i);
            if (sel[i] && pos >= regs.range_begin && pos < regs.range_end) begin
                if (match_total != COUNT_MAX)
                    match_total++;
                if (regs.emit_positions) begin
                    // hold each result back one step so the last can be marked
                    if (have)
                        owed_results.push_back(r);
                    r.position  = pos[POS_BITS-1:0];
                    r.pos_valid = 1'b1;
                    r.count     = match_total;
                    r.item_last = 1'b0;
                    r.done      = 1'b0;
                    have        = 1;
                end
            end
        end
        if (!have) begin
            r.position  = '0;
            r.pos_valid = 1'b0;
            r.count     = match_total;
        end
        r.item_last = 1'b1;
        r.done      = last_word;
        owed_results.push_back(r);
        if (last_word) begin
            match_total = '0;
            scans_done++;
        end
    endfunction

    function void check_result(logic [POS_BITS-1:0] position, logic pos_valid,
                               logic [COUNT_BITS-1:0] count, logic item_last, logic done);
        t_scan_result e;
        results_seen++;
        if (owed_results.size() == 0) begin
            $error("result with none owed: position %0d count %0d", position, count);
            errors++;
            return;
        end
        e = owed_results.pop_front();
        if (pos_valid)
            positions_seen++;
        if (position !== e.position) begin
            $error("position: expected %0d, got %0d", e.position, position);
            errors++;
        end
        if (pos_valid !== e.pos_valid) begin
            $error("position_valid: expected %0d, got %0d", e.pos_valid, pos_valid);
            errors++;
        end
        if (count !== e.count) begin
            $error("running_count: expected %0d, got %0d", e.count, count);
            errors++;
        end
        if (item_last !== e.item_last) begin
            $error("last_of_item: expected %0d, got %0d", e.item_last, item_last);
            errors++;
        end
        if (done !== e.done) begin
            $error("scan_done: expected %0d, got %0d", e.done, done);
            errors++;
        end
    endfunction

    function int pending();
        return owed_results.size();
    endfunction
endclass

module bit_range_scan_enumerate_count_unit_tb;

    localparam int                    CYCLE_LIMIT   = 2_000_000;
    localparam int                    SETTLE_CYCLES = 8;
    localparam int                    RANDOM_WORDS  = 400;
    localparam logic [MODE_BITS-1:0]  MODE_SPARE    = 2'd3;
    localparam logic [RANGE_BITS-1:0] RANGE_TOP     = 33'h1_0000_0000;
    localparam logic [INDEX_BITS-1:0] IDX_MAX       = '1;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_cfg_valid     = 1'b0;
    logic                      o_cfg_ready;
    logic [REG_IDX_BITS-1:0]   i_cfg_index     = REG_MATCH_MODE;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data      = '0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata  = '0;
    logic                      i_s_axis_tlast  = 1'b0;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;
    logic                      o_m_axis_tlast;
    logic [OUT_TUSER_BITS-1:0] o_m_axis_tuser;

    match_tracker tracker = new();

    // Stimulus knobs shared between the word driver and the result side.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          quiet       = 1'b0;   // no idling on either side
    bit          rx_hold_req = 1'b0;   // ask the result side for a long hold-off
    int          words_sent  = 0;
    int          settings    = 0;
    int unsigned cycle_count = 0;

    bit_range_scan_enumerate_count_unit u_top (.*);

    always #2 i_clk = ~i_clk;

    // Watchdog: give up well beyond the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check every accepted result request against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_result(o_m_axis_tdata[POS_BITS-1:0],
                                 o_m_axis_tuser[TUSER_POS_VALID],
                                 o_m_axis_tdata[POS_BITS +: COUNT_BITS],
                                 o_m_axis_tlast,
                                 o_m_axis_tuser[TUSER_SCAN_DONE]);
    end

    // Result side: random stalls in bursts, plus one long hold-off on request.
    initial begin : rx_side
        int gap;
        int hold;
        gap  = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                hold        = 400;
                rx_hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else if (!quiet && gap > 0) begin
                gap--;
                i_m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
                gap = $urandom_range(0, 14);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one word and hold it until the unit takes the request.
    task automatic send_word(logic [INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] first,
                             logic [WORD_BITS-1:0] second, logic last_word);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_BITS - IN_FIELD_BITS){1'b0}}, second, first, idx};
        i_s_axis_tlast  <= last_word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_word(idx, first, second, last_word);
        words_sent++;
    endtask

    // Drop valid for a random burst now and then.
    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Stop offering words and wait until every owed result has arrived.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Present one register write; valid is left high for a following write.
    task automatic put_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, value);
    endtask

    // Write all four registers back to back; call only while the unit is idle.
    task automatic configure(logic [MODE_BITS-1:0] mode, logic [RANGE_BITS-1:0] lo,
                             logic [RANGE_BITS-1:0] hi, logic emit);
        put_reg(REG_MATCH_MODE, CFG_DATA_BITS'(mode));
        put_reg(REG_RANGE_BEGIN, lo);
        put_reg(REG_RANGE_END, hi);
        put_reg(REG_EMIT_POS, CFG_DATA_BITS'(emit));
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [WORD_BITS-1:0] pick_word();
        logic [WORD_BITS-1:0] w;
        case ($urandom_range(0, 5))
            0: w = {$urandom, $urandom};
            1: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            2: w = {$urandom, $urandom} | {$urandom, $urandom};
            3: w = '1;
            4: w = '0;
            default: w = 64'd1 << $urandom_range(0, 63);
        endcase
        return w;
    endfunction

    // Clip a position bound to the largest legal register value.
    function automatic logic [RANGE_BITS-1:0] clip(longint unsigned v);
        return (v > RANGE_TOP) ? RANGE_TOP : RANGE_BITS'(v);
    endfunction

    initial begin : stimulus
        int                     phase;
        int                     n;
        longint unsigned        region_word;
        longint unsigned        region_pos;
        longint unsigned        lo;
        longint unsigned        hi;
        logic [INDEX_BITS-1:0]  idx;
        logic [MODE_BITS-1:0]   mode;
        logic                   last_word;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: empty range, positions on, so a count-only result.
        send_word('0, '1, '0, 1'b1);

        drain();
        configure(MODE_ONES, '0, RANGE_TOP, 1'b1);
        send_word('0, '1, '0, 1'b0);
        send_word(26'd1, '0, '1, 1'b0);
        send_word(IDX_MAX, 64'h8000_0000_0000_0001, '0, 1'b1);

        drain();
        configure(MODE_ZEROS, '0, RANGE_TOP, 1'b1);
        send_word(26'd3, '0, '0, 1'b0);
        send_word(26'd4, '1, '0, 1'b1);

        drain();
        configure(MODE_AND, '0, RANGE_TOP, 1'b1);
        send_word(26'd5, 64'hF0F0_F0F0_F0F0_F0F0, 64'hFF00_FF00_FF00_FF00, 1'b0);
        send_word(26'd6, '1, '0, 1'b1);

        // The spare mode code behaves as the AND mode.
        drain();
        configure(MODE_SPARE, '0, RANGE_TOP, 1'b1);
        send_word(26'd7, '1, 64'h5555_5555_5555_5555, 1'b1);

        // Range that starts and ends inside words.
        drain();
        configure(MODE_ONES, 33'd70, 33'd130, 1'b1);
        send_word(26'd1, '1, '0, 1'b0);
        send_word(26'd2, '1, '0, 1'b1);

        // Reversed and empty ranges match nothing.
        drain();
        configure(MODE_ONES, 33'd100, 33'd50, 1'b1);
        send_word(26'd1, '1, '0, 1'b1);
        drain();
        configure(MODE_ONES, 33'd64, 33'd64, 1'b1);
        send_word(26'd1, '1, '0, 1'b1);

        // Counts only.
        drain();
        configure(MODE_ONES, '0, RANGE_TOP, 1'b0);
        send_word('0, '1, '0, 1'b0);
        send_word(IDX_MAX, 64'hA5A5_A5A5_A5A5_A5A5, '0, 1'b1);

        // Only the very top position lies inside the range.
        drain();
        configure(MODE_ONES, RANGE_TOP - 1, RANGE_TOP, 1'b1);
        send_word(IDX_MAX, '1, '0, 1'b1);
        send_word(IDX_MAX, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b1);

        // Random scans in batches, each batch under its own register setting.
        phase = 0;
        while (words_sent < RANDOM_WORDS + 19) begin
            case ($urandom_range(0, 3))
                1:       region_word = 64'h3FF_FFFF - 127;
                2:       region_word = $urandom_range(0, 32'h3FF_FFFF - 127);
                default: region_word = 0;
            endcase
            region_pos = region_word * 64;
            case ($urandom_range(0, 5))
                0: begin lo = 0; hi = RANGE_TOP; end
                1: begin lo = region_pos + $urandom_range(0, 6400);
                         hi = lo + $urandom_range(1, 4096); end
                2: begin lo = region_pos + $urandom_range(0, 6400); hi = lo; end
                3: begin hi = region_pos + $urandom_range(0, 6400);
                         lo = hi + $urandom_range(1, 4096); end
                4: begin lo = region_pos + $urandom_range(0, 6400); hi = RANGE_TOP; end
                default: begin lo = 0; hi = region_pos + $urandom_range(0, 6400); end
            endcase
            mode = MODE_BITS'($urandom_range(0, 3));

            drain();
            configure(mode, clip(lo), clip(hi), $urandom_range(0, 4) != 0);

            quiet = (words_sent >= RANDOM_WORDS + 19 - 60);
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 10;
                default: tx_idle_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 5;
                default: rx_idle_pct = 20;
            endcase
            // Stall the result side for a long stretch while words keep coming.
            if (phase == 2) begin
                rx_hold_req = 1'b1;
                tx_idle_pct = 0;
            end

            n   = $urandom_range(4, 20);
            idx = INDEX_BITS'(region_word + $urandom_range(0, 100));
            for (int k = 0; k < n; k++) begin
                last_word = (k == n - 1) || ($urandom_range(0, 19) == 0);
                send_word(idx, pick_word(), pick_word(), last_word);
                maybe_gap();
                // Pause the sender mid-scan until every owed result is in.
                if (phase == 4 && k == n / 2)
                    drain();
                case ($urandom_range(0, 15))
                    0:       idx = INDEX_BITS'($urandom);
                    1, 2:    idx = INDEX_BITS'(region_word + $urandom_range(0, 100));
                    default: idx = idx + 1'b1;
                endcase
            end
            phase++;
        end

        drain();
        $display("Checked %0d words in %0d scans under %0d register settings:",
                 words_sent, tracker.scans_done, settings);
        $display("%0d result requests, %0d of them carrying a position.",
                 tracker.results_seen, tracker.positions_seen);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
